FILE: hw/rtl/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Types and constants shared by the descending score record sorter.
// ----------------------------------------------------------------------------
package rsd_pkg;

	localparam int SCORE_W         = 10;
	localparam int ID_W            = 27;
	localparam int IDX_W           = 7;
	localparam int MAX_RECORDS_DEF = 128;

	// Request kinds.
	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_READ = 1'b1
	} req_kind_t;

	// One request word.
	typedef struct packed {
		req_kind_t          req_type;
		logic [SCORE_W-1:0] score;
		logic [ID_W-1:0]    student_id;
		logic               is_last;
		logic [IDX_W-1:0]   read_index;
	} req_t;

	// One result word.
	typedef struct packed {
		logic [SCORE_W-1:0] out_score;
		logic [ID_W-1:0]    out_id;
		logic               out_found;
		logic               out_overflowed;
	} res_t;

	// One stored record.
	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [ID_W-1:0]    id;
	} rec_t;

endpackage

FILE: hw/rtl/record_sort_descending_by_score_top.sv
// ----------------------------------------------------------------------------
// record_sort_descending_by_score_top
// Record store with an in-place exchange sort into descending score order.
// ----------------------------------------------------------------------------
// Load word: taken while idle, no result. A load marked last that leaves two
//   or more records raises busy for the sort, which uses the single read and
//   single write port of the store.
// Read word: taken while idle, result strobed in the next cycle; reads may
//   follow each other every cycle while not busy. The receiver cannot stall.
// Reset clears count, set and overflow state; store contents are not cleared.
module record_sort_descending_by_score_top #(
	parameter int MAX_RECORDS = rsd_pkg::MAX_RECORDS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rsd_pkg::req_t req,
	output logic          valid,
	output rsd_pkg::res_t res
);
	import rsd_pkg::*;

	localparam int AW   = $clog2(MAX_RECORDS);
	localparam int CW   = $clog2(MAX_RECORDS + 1);
	localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOADA,
		S_SCAN
	} state_t;

	typedef enum logic [1:0] {
		TAG_NONE,
		TAG_A,
		TAG_B
	} tag_t;

	state_t          state_q;
	tag_t            tag_s1;
	logic [CW-1:0]   count_q;
	logic            closed_q;
	logic            ovf_q;
	logic [CW-1:0]   a_q;
	logic [CW-1:0]   b_q;
	logic [CW-1:0]   n_q;
	logic [CW-1:0]   b_s1;
	rec_t            held_q;
	logic            valid_q;
	logic            found_s1;
	logic            ovf_s1;

	rec_t            mem_q [MAX_RECORDS];
	rec_t            rd_data_s1;

	logic            acc;
	logic            ld;
	logic            rdq;
	logic [CW-1:0]   cnt_base;
	logic            room;
	logic [CW-1:0]   new_cnt;
	logic [CMPW-1:0] pos_w;
	logic            found;
	logic            hit;
	logic            scan_end;
	logic            more_a;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	rec_t            wr_data;

	// Request decode.
	assign busy     = (state_q != S_IDLE);
	assign acc      = start && !busy;
	assign ld       = acc && (req.req_type == REQ_LOAD);
	assign rdq      = acc && (req.req_type == REQ_READ);
	assign cnt_base = closed_q ? '0 : count_q;
	assign room     = (cnt_base < CW'(MAX_RECORDS));
	assign new_cnt  = room ? (cnt_base + CW'(1)) : cnt_base;
	assign pos_w    = CMPW'(req.read_index);
	assign found    = (pos_w < CMPW'(count_q));

	// Sort control: a later record with a higher score trades places with the held one.
	assign hit      = (tag_s1 == TAG_B) && (held_q.score < rd_data_s1.score);
	assign scan_end = (state_q == S_SCAN) && (b_q == n_q) && (tag_s1 == TAG_NONE);
	assign more_a   = (({1'b0, a_q} + (CW+1)'(2)) < {1'b0, n_q});

	// Read port selection.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			S_IDLE: begin
				rd_en   = rdq;
				rd_addr = pos_w[AW-1:0];
			end
			S_LOADA: begin
				rd_en   = 1'b1;
				rd_addr = a_q[AW-1:0];
			end
			S_SCAN: begin
				rd_en   = (b_q < n_q);
				rd_addr = b_q[AW-1:0];
			end
			default: begin
				rd_en   = 1'b0;
			end
		endcase
	end

	// Write port selection.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = held_q;
		if (ld && room) begin
			wr_en   = 1'b1;
			wr_addr = cnt_base[AW-1:0];
			wr_data = '{score: req.score, id: req.student_id};
		end else if (hit) begin
			wr_en   = 1'b1;
			wr_addr = b_s1[AW-1:0];
		end else if (scan_end) begin
			wr_en   = 1'b1;
			wr_addr = a_q[AW-1:0];
		end
	end

	// Record memory.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	// Held record and address of the word in flight.
	always_ff @(posedge clk) begin
		b_s1 <= b_q;
		if ((tag_s1 == TAG_A) || hit) begin
			held_q <= rd_data_s1;
		end
	end

	// State machine with set bookkeeping and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			tag_s1   <= TAG_NONE;
			count_q  <= '0;
			closed_q <= 1'b0;
			ovf_q    <= 1'b0;
			a_q      <= '0;
			b_q      <= '0;
			n_q      <= '0;
			valid_q  <= 1'b0;
			found_s1 <= 1'b0;
			ovf_s1   <= 1'b0;
		end else begin
			valid_q  <= rdq;
			found_s1 <= found;
			ovf_s1   <= ovf_q;
			unique case (state_q)
				S_IDLE: begin
					tag_s1 <= TAG_NONE;
					if (ld) begin
						count_q  <= new_cnt;
						closed_q <= req.is_last;
						ovf_q    <= (closed_q ? 1'b0 : ovf_q) | !room;
						if (req.is_last && (new_cnt >= CW'(2))) begin
							a_q     <= '0;
							n_q     <= new_cnt;
							state_q <= S_LOADA;
						end
					end
				end
				S_LOADA: begin
					b_q     <= a_q + CW'(1);
					tag_s1  <= TAG_A;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (b_q < n_q) begin
						tag_s1 <= TAG_B;
						b_q    <= b_q + CW'(1);
					end else begin
						tag_s1 <= TAG_NONE;
					end
					if (scan_end) begin
						if (more_a) begin
							a_q     <= a_q + CW'(1);
							state_q <= S_LOADA;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result word.
	assign valid              = valid_q;
	assign res.out_score      = found_s1 ? rd_data_s1.score : '0;
	assign res.out_id         = found_s1 ? rd_data_s1.id : '0;
	assign res.out_found      = found_s1;
	assign res.out_overflowed = ovf_s1;

endmodule

FILE: hw/rtl/rsd_checker.sv
// ----------------------------------------------------------------------------
// rsd_checker
// Port-level checks for the descending score record sorter.
// ----------------------------------------------------------------------------
module rsd_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input rsd_pkg::req_t req,
	input logic          valid,
	input rsd_pkg::res_t res
);
	import rsd_pkg::*;

	// An accepted read word gives a result in the next cycle.
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req.req_type == REQ_READ)) |=> valid)
		else $error("read word without result");

	// A result only follows an accepted read word.
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(start && !busy && (req.req_type == REQ_READ)))
		else $error("result without read word");

	// A position past the count returns zero fields.
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !res.out_found) |-> ((res.out_score == '0) && (res.out_id == '0)))
		else $error("missing record returned nonzero fields");

	// The sort starts only after a load word marked last.
	a_sort_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && (req.req_type == REQ_LOAD) && req.is_last))
		else $error("sort started without closing load");

endmodule

bind record_sort_descending_by_score_top rsd_checker u_rsd_checker (.*);

FILE: test/record_sort_descending_by_score_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// record_sort_descending_by_score_checker
// Watches the request and result channels of the record sorter, keeps a
// shadow copy of the record store, and checks every read result against it.
// ----------------------------------------------------------------------------
module record_sort_descending_by_score_checker #(
	parameter int MAX_RECORDS = rsd_pkg::MAX_RECORDS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  rsd_pkg::req_t req,
	input  logic          valid,
	input  rsd_pkg::res_t res,
	output int            fail_count,
	output int            pending,
	output int            loads_seen,
	output int            reads_seen,
	output int            sets_closed,
	output int            misses_seen,
	output int            overflow_reads
);
	import rsd_pkg::*;

	// Shadow store, count and set state.
	rec_t        shadow_recs [MAX_RECORDS];
	int unsigned rec_cnt;
	bit          set_done;
	bit          dropped;

	// Read results still to come, oldest first.
	res_t        ranked_q [$];

	// In-place exchange sort into descending score order, same swap order
	// as the block, so equal scores land where the block puts them.
	function automatic void exchange_sort_desc();
		rec_t tmp;
		for (int a = 0; a + 1 < int'(rec_cnt); a++) begin
			for (int b = a + 1; b < int'(rec_cnt); b++) begin
				if (shadow_recs[a].score < shadow_recs[b].score) begin
					tmp            = shadow_recs[a];
					shadow_recs[a] = shadow_recs[b];
					shadow_recs[b] = tmp;
				end
			end
		end
	endfunction

	// Update the shadow state for one accepted word; a read queues a result.
	function automatic void apply_request(input req_t w);
		res_t e;
		if (w.req_type == REQ_LOAD) begin
			if (set_done) begin
				rec_cnt  = 0;
				set_done = 1'b0;
				dropped  = 1'b0;
			end
			if (rec_cnt < MAX_RECORDS) begin
				shadow_recs[rec_cnt] = {w.score, w.student_id};
				rec_cnt++;
			end else begin
				dropped = 1'b1;
			end
			if (w.is_last) begin
				set_done = 1'b1;
				exchange_sort_desc();
				sets_closed++;
			end
			loads_seen++;
		end else begin
			e = '0;
			if (w.read_index < rec_cnt) begin
				e.out_score = shadow_recs[w.read_index].score;
				e.out_id    = shadow_recs[w.read_index].id;
				e.out_found = 1'b1;
			end else begin
				misses_seen++;
			end
			e.out_overflowed = dropped;
			if (dropped)
				overflow_reads++;
			reads_seen++;
			ranked_q.push_back(e);
		end
	endfunction

	// Count a failure; only the first ten are printed.
	function automatic void flag_mismatch(input string what, input res_t e, input res_t a);
		if (fail_count < 10) begin
			$display("[%0t] %s: expected score=%0d id=%0d found=%0d ovf=%0d,",
				$realtime, what, e.out_score, e.out_id, e.out_found, e.out_overflowed);
			$display("          got score=%0d id=%0d found=%0d ovf=%0d",
				a.out_score, a.out_id, a.out_found, a.out_overflowed);
		end
		fail_count++;
	endfunction

	initial begin
		fail_count     = 0;
		pending        = 0;
		loads_seen     = 0;
		reads_seen     = 0;
		sets_closed    = 0;
		misses_seen    = 0;
		overflow_reads = 0;
		rec_cnt        = 0;
		set_done       = 1'b0;
		dropped        = 1'b0;
	end

	// Results are checked before the word taken at the same edge is applied.
	always @(posedge clk) begin
		res_t e;
		if (!arst_n) begin
			rec_cnt  = 0;
			set_done = 1'b0;
			dropped  = 1'b0;
		end else begin
			if (valid) begin
				if (ranked_q.size() == 0) begin
					flag_mismatch("result with no read waiting", '0, res);
				end else begin
					e = ranked_q.pop_front();
					if (res.out_score !== e.out_score || res.out_id !== e.out_id ||
					    res.out_found !== e.out_found ||
					    res.out_overflowed !== e.out_overflowed)
						flag_mismatch("read result differs", e, res);
				end
			end
			if (start && !busy)
				apply_request(req);
		end
		pending = ranked_q.size();
	end

endmodule

FILE: test/record_sort_descending_by_score_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// record_sort_descending_by_score_top_tb
// Drives load and read words into the record sorter under several idle
// patterns and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module record_sort_descending_by_score_top_tb;
	import rsd_pkg::*;

	localparam int MAX_RECORDS = MAX_RECORDS_DEF;
	// Leave wide margin over the longest sort, that of a full store.
	localparam int STALL_LIMIT = 60000;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic valid;
	res_t res;

	int fail_count;
	int pending;
	int loads_seen;
	int reads_seen;
	int sets_closed;
	int misses_seen;
	int overflow_reads;

	int idle_pct   = 0;
	int words_sent = 0;
	int quiet_cyc  = 0;

	record_sort_descending_by_score_top #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.valid (valid),
		.res   (res)
	);

	record_sort_descending_by_score_checker #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req           (req),
		.valid         (valid),
		.res           (res),
		.fail_count    (fail_count),
		.pending       (pending),
		.loads_seen    (loads_seen),
		.reads_seen    (reads_seen),
		.sets_closed   (sets_closed),
		.misses_seen   (misses_seen),
		.overflow_reads(overflow_reads)
	);

	always #5 clk = ~clk;

	// Watchdog: too many cycles without a word taken ends the run.
	always @(posedge clk) begin
		if (start && !busy) begin
			quiet_cyc <= 0;
		end else begin
			quiet_cyc <= quiet_cyc + 1;
			if (quiet_cyc >= STALL_LIMIT) begin
				$display("Watchdog: no word taken for %0d cycles", STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Load word; the read position is unused and left random.
	function automatic req_t load_word(input int sc, input int tag, input bit last);
		req_t w;
		w.req_type   = REQ_LOAD;
		w.score      = SCORE_W'(sc);
		w.student_id = ID_W'(tag);
		w.is_last    = last;
		w.read_index = IDX_W'($urandom_range(127));
		return w;
	endfunction

	// Read word; the load fields are unused and left random.
	function automatic req_t read_word(input int idx);
		req_t w;
		w.req_type   = REQ_READ;
		w.score      = SCORE_W'($urandom_range(1000));
		w.student_id = ID_W'($urandom_range(99999999));
		w.is_last    = 1'($urandom_range(1));
		w.read_index = IDX_W'(idx);
		return w;
	endfunction

	// Offer one word after a random gap and hold it until it is taken.
	task automatic send_word(input req_t w);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		words_sent++;
	endtask

	// Stop sending until every queued read result has come back.
	task automatic drain_results();
		int guard;
		guard = 0;
		start <= 1'b0;
		do begin
			@(negedge clk);
			guard++;
		end while (pending != 0 && guard < 1000);
		@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int n;
		int n_eff;
		int m;
		int idx;
		int sc;
		int roll;
		int big_sets;
		bit tie_mode;
		big_sets = 0;
		arst_n <= 1'b0;
		start  <= 1'b0;
		req    <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty store, open-set reads, ties, extremes, new set.
		send_word(read_word(0));
		send_word(read_word(127));
		send_word(load_word(1000, 99999999, 1'b0));
		send_word(load_word(0, 0, 1'b0));
		send_word(read_word(0));
		send_word(read_word(1));
		send_word(read_word(2));
		send_word(load_word(500, 12345678, 1'b0));
		send_word(load_word(1000, 1, 1'b0));
		send_word(load_word(0, 67108863, 1'b0));
		send_word(load_word(500, 2, 1'b1));
		for (int k = 0; k <= 6; k++)
			send_word(read_word(k));
		send_word(read_word(127));
		send_word(load_word(1, 1, 1'b1));
		send_word(read_word(0));
		send_word(read_word(1));
		drain_results();

		// Random sets under changing idle patterns, drained between phases.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 3)
				0: idle_pct = 0;
				1: idle_pct = 45;
				default: idle_pct = 33;
			endcase
			while (words_sent < 22 + (ph + 1) * 200) begin
				roll = $urandom_range(99);
				if (roll < 5 && big_sets > 0) begin
					// Stray read between sets.
					send_word(read_word($urandom_range(127)));
				end else begin
					if (big_sets == 0) begin
						// First set overfills the store and its last word is dropped.
						n = MAX_RECORDS + 1;
						big_sets++;
					end else if (roll < 9 && big_sets < 4) begin
						n = $urandom_range(MAX_RECORDS - 2, MAX_RECORDS + 8);
						big_sets++;
					end else if (roll < 15) begin
						n = 1;
					end else begin
						n = $urandom_range(2, 16);
					end
					tie_mode = ($urandom_range(99) < 30);
					for (int k = 0; k < n; k++) begin
						if ($urandom_range(99) < 8)
							send_word(read_word($urandom_range(k < 127 ? k + 1 : 127)));
						if (tie_mode) begin
							case ($urandom_range(3))
								0: sc = 0;
								1: sc = 1000;
								2: sc = 500;
								default: sc = $urandom_range(1, 3);
							endcase
						end else begin
							sc = $urandom_range(1000);
						end
						// Small sets sometimes close early, which splits them.
						send_word(load_word(sc, $urandom_range(99999999),
							(k == n - 1) || (n <= 100 && $urandom_range(99) < 2)));
					end
					n_eff = (n > 127) ? 127 : n;
					m = (n > 100) ? n_eff + 1 : $urandom_range(1, n + 3);
					for (int k = 0; k < m; k++) begin
						if (n > 100)
							idx = k;
						else if ($urandom_range(99) < 80)
							idx = $urandom_range(n_eff);
						else
							idx = $urandom_range(127);
						send_word(read_word(idx));
					end
				end
			end
			drain_results();
		end

		repeat (20) @(posedge clk);
		$display("Covered %0d loads in %0d closed sets and %0d reads,",
			loads_seen, sets_closed, reads_seen);
		$display("  %0d reads past the count and %0d with records dropped.",
			misses_seen, overflow_reads);
		if (fail_count == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d failures, %0d results never arrived", fail_count, pending);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
